[rtl/ihd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Shared widths, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package ihd_pkg;

  localparam int unsigned NODE_CAPACITY = 65536;
  localparam int unsigned NODE_W        = 16;
  localparam int unsigned SLOT_W        = 16;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned CNT_W         = 17;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned IN_DATA_W     = 56;
  localparam int unsigned OUT_DATA_W    = 72;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DECREASED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_UP,
    S_UP_PN,
    S_UP_CMP,
    S_POP_TOP,
    S_POP_LAST,
    S_POP_LKEY,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FIN
  } state_e;

endpackage

[rtl/ihd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ihd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/indexed_min_heap_decrease_key.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed min-heap with decrease-key
// Priority queue of node identifiers ordered by key, with a slot map per node.
// ----------------------------------------------------------------------------
// Clear, unused mode and empty pop go straight to the result. Insert reads the
// slot map; a new node or a lower key climbs (parent read, parent key, compare),
// else it is ignored. Pop reads the top and the last node and, unless that
// empties the heap, sinks the last node (left child, right child, compare).
// One item at a time; the next is accepted after the result is registered.
// After reset the position memory is swept before any item is accepted.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mode[1:0], node_id[17:2], priority_req[49:18], zeros above
  input  logic [ihd_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_node[15:0], out_priority[47:16], status[50:48], occupancy[67:51],
  // zeros above
  output logic [ihd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned NW = ihd_pkg::NODE_W;
  localparam int unsigned SW = ihd_pkg::SLOT_W;
  localparam int unsigned KW = ihd_pkg::KEY_W;
  localparam int unsigned CW = ihd_pkg::CNT_W;

  ihd_pkg::state_e state_q, state_d;

  logic [CW-1:0]               cnt_q, cnt_d;
  logic [SW-1:0]               init_q, init_d;
  logic [NW-1:0]               node_q, node_d;
  logic [KW-1:0]               key_q, key_d;
  logic [SW-1:0]               slot_q, slot_d;
  logic [NW-1:0]               pn_q, pn_d;
  logic [NW-1:0]               rn_q, rn_d;
  logic [KW-1:0]               lk_q, lk_d;
  logic [NW-1:0]               top_q, top_d;
  logic [KW-1:0]               topkey_q, topkey_d;
  logic [ihd_pkg::STATUS_W-1:0] status_q, status_d;
  logic                        ovalid_q, ovalid_d;
  logic [NW-1:0]               onode_q, onode_d;
  logic [KW-1:0]               okey_q, okey_d;
  logic [ihd_pkg::STATUS_W-1:0] ostatus_q, ostatus_d;
  logic [CW-1:0]               occ_q, occ_d;

  logic          heap_we, pos_we, key_we;
  logic [SW-1:0] heap_waddr, heap_raddr, pos_wdata, pos_rdata;
  logic [NW-1:0] heap_wdata, heap_rdata, pos_waddr, pos_raddr, key_waddr, key_raddr;
  logic [KW-1:0] key_wdata, key_rdata;

  logic                       acc;
  logic [ihd_pkg::MODE_W-1:0] in_mode;
  logic [NW-1:0]              in_node;
  logic [KW-1:0]              in_key;
  logic                       present, lower, out_free;
  logic [CW:0]                left, right;
  logic                       left_ok, right_ok, use_r, dn_move, up_move;
  logic [KW-1:0]              child_key;

  assign in_mode = s_axis_tdata[1:0];
  assign in_node = s_axis_tdata[17:2];
  assign in_key  = s_axis_tdata[49:18];

  assign s_axis_tready = (state_q == ihd_pkg::S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  assign present   = ({1'b0, slot_q} < cnt_q) && (heap_rdata == node_q);
  assign lower     = key_q < key_rdata;
  assign left      = {1'b0, slot_q, 1'b1};
  assign right     = left + 1'b1;
  assign left_ok   = left < {1'b0, cnt_q};
  assign right_ok  = right < {1'b0, cnt_q};
  assign use_r     = right_ok && (key_rdata < lk_q);
  assign child_key = use_r ? key_rdata : lk_q;
  assign dn_move   = child_key < key_q;
  assign up_move   = !(key_rdata <= key_q);

  ihd_ram #(.WIDTH(NW), .DEPTH(ihd_pkg::NODE_CAPACITY)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  ihd_ram #(.WIDTH(SW), .DEPTH(ihd_pkg::NODE_CAPACITY)) u_pos (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  ihd_ram #(.WIDTH(KW), .DEPTH(ihd_pkg::NODE_CAPACITY)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ihd_pkg::S_INIT: begin
        if (init_q == {SW{1'b1}}) state_d = ihd_pkg::S_IDLE;
      end
      ihd_pkg::S_IDLE: begin
        if (acc) begin
          if (in_mode == ihd_pkg::MODE_INSERT) begin
            state_d = ihd_pkg::S_INS_RD;
          end else if (in_mode == ihd_pkg::MODE_POP && cnt_q != '0) begin
            state_d = ihd_pkg::S_POP_TOP;
          end else begin
            state_d = ihd_pkg::S_FIN;
          end
        end
      end
      ihd_pkg::S_INS_RD:   state_d = ihd_pkg::S_INS_CHK;
      ihd_pkg::S_INS_CHK: begin
        state_d = (!present || lower) ? ihd_pkg::S_UP : ihd_pkg::S_FIN;
      end
      ihd_pkg::S_UP: begin
        state_d = (slot_q == '0) ? ihd_pkg::S_FIN : ihd_pkg::S_UP_PN;
      end
      ihd_pkg::S_UP_PN:    state_d = ihd_pkg::S_UP_CMP;
      ihd_pkg::S_UP_CMP: begin
        state_d = up_move ? ihd_pkg::S_UP : ihd_pkg::S_FIN;
      end
      ihd_pkg::S_POP_TOP:  state_d = ihd_pkg::S_POP_LAST;
      ihd_pkg::S_POP_LAST: begin
        state_d = (cnt_q == '0) ? ihd_pkg::S_FIN : ihd_pkg::S_POP_LKEY;
      end
      ihd_pkg::S_POP_LKEY: state_d = ihd_pkg::S_DN;
      ihd_pkg::S_DN: begin
        state_d = left_ok ? ihd_pkg::S_DN_L : ihd_pkg::S_FIN;
      end
      ihd_pkg::S_DN_L:     state_d = ihd_pkg::S_DN_R;
      ihd_pkg::S_DN_R:     state_d = ihd_pkg::S_DN_CMP;
      ihd_pkg::S_DN_CMP: begin
        state_d = dn_move ? ihd_pkg::S_DN : ihd_pkg::S_FIN;
      end
      ihd_pkg::S_FIN: begin
        if (out_free) state_d = ihd_pkg::S_IDLE;
      end
      default: state_d = ihd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    init_d    = init_q;
    node_d    = node_q;
    key_d     = key_q;
    slot_d    = slot_q;
    pn_d      = pn_q;
    rn_d      = rn_q;
    lk_d      = lk_q;
    top_d     = top_q;
    topkey_d  = topkey_q;
    status_d  = status_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    onode_d   = onode_q;
    okey_d    = okey_q;
    ostatus_d = ostatus_q;
    occ_d     = occ_q;

    heap_we    = 1'b0;
    heap_waddr = slot_q;
    heap_wdata = node_q;
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = node_q;
    pos_wdata  = slot_q;
    pos_raddr  = in_node;
    key_we     = 1'b0;
    key_waddr  = node_q;
    key_wdata  = key_q;
    key_raddr  = node_q;

    unique case (state_q)
      ihd_pkg::S_INIT: begin
        pos_we    = 1'b1;
        pos_waddr = init_q;
        pos_wdata = '0;
        init_d    = init_q + 1'b1;
      end
      ihd_pkg::S_IDLE: begin
        if (acc) begin
          node_d   = in_node;
          key_d    = in_key;
          status_d = ihd_pkg::ST_IGNORED;
          if (in_mode == ihd_pkg::MODE_POP) begin
            status_d = (cnt_q == '0) ? ihd_pkg::ST_EMPTY : ihd_pkg::ST_POPPED;
          end else if (in_mode == ihd_pkg::MODE_CLEAR) begin
            status_d = ihd_pkg::ST_CLEARED;
            cnt_d    = '0;
          end
        end
      end
      ihd_pkg::S_INS_RD: begin
        heap_raddr = pos_rdata;
        slot_d     = pos_rdata;
      end
      ihd_pkg::S_INS_CHK: begin
        if (!present) begin
          key_we   = 1'b1;
          slot_d   = cnt_q[SW-1:0];
          cnt_d    = cnt_q + 1'b1;
          status_d = ihd_pkg::ST_INSERTED;
        end else if (lower) begin
          key_we   = 1'b1;
          status_d = ihd_pkg::ST_DECREASED;
        end else begin
          status_d = ihd_pkg::ST_IGNORED;
        end
      end
      ihd_pkg::S_UP: begin
        heap_raddr = (slot_q - 1'b1) >> 1;
        if (slot_q == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      ihd_pkg::S_UP_PN: begin
        pn_d      = heap_rdata;
        key_raddr = heap_rdata;
      end
      ihd_pkg::S_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (up_move) begin
          heap_wdata = pn_q;
          pos_waddr  = pn_q;
          slot_d     = (slot_q - 1'b1) >> 1;
        end
      end
      ihd_pkg::S_POP_TOP: begin
        top_d      = heap_rdata;
        key_raddr  = heap_rdata;
        cnt_d      = cnt_q - 1'b1;
        heap_raddr = cnt_d[SW-1:0];
      end
      ihd_pkg::S_POP_LAST: begin
        topkey_d  = key_rdata;
        node_d    = heap_rdata;
        key_raddr = heap_rdata;
      end
      ihd_pkg::S_POP_LKEY: begin
        key_d  = key_rdata;
        slot_d = '0;
      end
      ihd_pkg::S_DN: begin
        heap_raddr = left[SW-1:0];
        if (!left_ok) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      ihd_pkg::S_DN_L: begin
        pn_d       = heap_rdata;
        key_raddr  = heap_rdata;
        heap_raddr = right[SW-1:0];
      end
      ihd_pkg::S_DN_R: begin
        lk_d      = key_rdata;
        rn_d      = heap_rdata;
        key_raddr = heap_rdata;
      end
      ihd_pkg::S_DN_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (dn_move) begin
          heap_wdata = use_r ? rn_q : pn_q;
          pos_waddr  = use_r ? rn_q : pn_q;
          slot_d     = use_r ? right[SW-1:0] : left[SW-1:0];
        end
      end
      ihd_pkg::S_FIN: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          occ_d     = cnt_q;
          if (status_q == ihd_pkg::ST_POPPED) begin
            onode_d = top_q;
            okey_d  = topkey_q;
          end else begin
            onode_d = '0;
            okey_d  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ihd_pkg::S_INIT;
      cnt_q    <= '0;
      init_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      init_q   <= init_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    key_q     <= key_d;
    slot_q    <= slot_d;
    pn_q      <= pn_d;
    rn_q      <= rn_d;
    lk_q      <= lk_d;
    top_q     <= top_d;
    topkey_q  <= topkey_d;
    status_q  <= status_d;
    onode_q   <= onode_d;
    okey_q    <= okey_d;
    ostatus_q <= ostatus_d;
    occ_q     <= occ_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0, occ_q, ostatus_q, okey_q, onode_q};

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed min-heap testbench
// Drives insert, decrease, pop and clear items with random bursts and sink
// stalls, predicts each result with a behavioural heap and checks it.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [ihd_pkg::MODE_W-1:0] mode;
    logic [ihd_pkg::NODE_W-1:0] node;
    logic [ihd_pkg::KEY_W-1:0]  key;
  } heap_op_t;

  typedef struct packed {
    logic [ihd_pkg::NODE_W-1:0]   node;
    logic [ihd_pkg::KEY_W-1:0]    key;
    logic [ihd_pkg::STATUS_W-1:0] status;
    logic [ihd_pkg::CNT_W-1:0]    occ;
  } heap_res_t;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ihd_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ihd_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  heap_op_t  pending_ops[$];
  heap_res_t expected_results[$];

  logic [ihd_pkg::NODE_W-1:0] slot_node[ihd_pkg::NODE_CAPACITY];
  int unsigned                node_slot[ihd_pkg::NODE_CAPACITY];
  bit                         node_in_heap[ihd_pkg::NODE_CAPACITY];
  logic [ihd_pkg::KEY_W-1:0]  node_key[ihd_pkg::NODE_CAPACITY];
  int unsigned                heap_size;

  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned pops_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  bit          all_sent = 1'b0;
  bit          ready_seen = 1'b0;

  always #10 clk_i = ~clk_i;

  indexed_min_heap_decrease_key i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic void place_node(int unsigned slot, logic [ihd_pkg::NODE_W-1:0] node);
    slot_node[slot] = node;
    node_slot[node] = slot;
  endfunction

  function automatic void climb(int unsigned slot, logic [ihd_pkg::NODE_W-1:0] node);
    int unsigned parent;
    while (slot > 0) begin
      parent = (slot - 1) / 2;
      if (node_key[slot_node[parent]] <= node_key[node]) break;
      place_node(slot, slot_node[parent]);
      slot = parent;
    end
    place_node(slot, node);
  endfunction

  function automatic void sink(logic [ihd_pkg::NODE_W-1:0] node);
    int unsigned slot;
    int unsigned child;
    slot = 0;
    forever begin
      if (2 * slot + 1 >= heap_size) break;
      child = 2 * slot + 1;
      if (child + 1 < heap_size &&
          node_key[slot_node[child + 1]] < node_key[slot_node[child]]) child = child + 1;
      if (!(node_key[slot_node[child]] < node_key[node])) break;
      place_node(slot, slot_node[child]);
      slot = child;
    end
    place_node(slot, node);
  endfunction

  function automatic heap_res_t apply_heap_op(heap_op_t op);
    heap_res_t r;
    logic [ihd_pkg::NODE_W-1:0] top;
    r = '0;
    r.status = ihd_pkg::ST_IGNORED;
    if (op.mode == ihd_pkg::MODE_INSERT) begin
      if (!node_in_heap[op.node]) begin
        node_in_heap[op.node] = 1'b1;
        node_key[op.node] = op.key;
        heap_size++;
        climb(heap_size - 1, op.node);
        r.status = ihd_pkg::ST_INSERTED;
      end else if (op.key < node_key[op.node]) begin
        node_key[op.node] = op.key;
        climb(node_slot[op.node], op.node);
        r.status = ihd_pkg::ST_DECREASED;
      end
    end else if (op.mode == ihd_pkg::MODE_POP) begin
      if (heap_size == 0) begin
        r.status = ihd_pkg::ST_EMPTY;
      end else begin
        top = slot_node[0];
        heap_size--;
        if (heap_size > 0) sink(slot_node[heap_size]);
        node_in_heap[top] = 1'b0;
        r.node = top;
        r.key = node_key[top];
        r.status = ihd_pkg::ST_POPPED;
      end
    end else if (op.mode == ihd_pkg::MODE_CLEAR) begin
      for (int i = 0; i < ihd_pkg::NODE_CAPACITY; i++) node_in_heap[i] = 1'b0;
      heap_size = 0;
      r.status = ihd_pkg::ST_CLEARED;
    end
    r.occ = heap_size[ihd_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic void queue_op(logic [ihd_pkg::MODE_W-1:0] mode,
                                   logic [ihd_pkg::NODE_W-1:0] node,
                                   logic [ihd_pkg::KEY_W-1:0] key);
    heap_op_t op;
    op.mode = mode;
    op.node = node;
    op.key = key;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [ihd_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [ihd_pkg::NODE_W-1:0] pool[8];
    heap_size = 0;
    for (int i = 0; i < ihd_pkg::NODE_CAPACITY; i++) node_in_heap[i] = 1'b0;

    // Directed: empty pop, key extremes, ties, decrease, not lower, mode three.
    queue_op(ihd_pkg::MODE_POP, 16'h0000, 32'h0);
    queue_op(ihd_pkg::MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(ihd_pkg::MODE_INSERT, 16'h0000, 32'h0000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'h5555, 32'h0000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'hAAAA, 32'h8000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'h1234, 32'h8000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'h00FF, 32'h8000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'hAAAA, 32'h8000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'hAAAA, 32'hFFFF_FFFF);
    queue_op(ihd_pkg::MODE_INSERT, 16'hFFFF, 32'h0000_0000);
    queue_op(ihd_pkg::MODE_INSERT, 16'h1234, 32'h5555_5555);
    queue_op(ihd_pkg::MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 7; i++) queue_op(ihd_pkg::MODE_POP, 16'h0000, 32'h0);
    queue_op(ihd_pkg::MODE_INSERT, 16'h0042, 32'hAAAA_AAAA);
    queue_op(ihd_pkg::MODE_INSERT, 16'h0043, 32'h0000_0001);
    queue_op(ihd_pkg::MODE_CLEAR, 16'h0000, 32'h0);
    queue_op(ihd_pkg::MODE_POP, 16'h0000, 32'h0);
    queue_op(ihd_pkg::MODE_INSERT, 16'h0042, 32'h0000_0007);
    queue_op(ihd_pkg::MODE_POP, 16'h0000, 32'h0);

    // Random: mostly inserts, some on a small pool to get decreases, so heaps get deep.
    for (int i = 0; i < 850; i++) begin
      int unsigned sel;
      if (i % 120 == 0)
        for (int j = 0; j < 8; j++) pool[j] = 16'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 55)
        queue_op(ihd_pkg::MODE_INSERT,
                 ($urandom_range(0, 2) == 0) ? pool[$urandom_range(0, 7)] : 16'($urandom),
                 rand_key());
      else if (sel < 90)
        queue_op(ihd_pkg::MODE_POP, 16'($urandom), $urandom);
      else if (sel < 97)
        queue_op(ihd_pkg::MODE_INSERT, pool[$urandom_range(0, 7)], $urandom_range(0, 1023));
      else if (sel < 99)
        queue_op(ihd_pkg::MODE_CLEAR, 16'($urandom), $urandom);
      else
        queue_op(ihd_pkg::MODE_UNUSED, 16'($urandom), $urandom);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk_i) begin
    heap_op_t op;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        op = pending_ops.pop_front();
        expected_results.push_back(apply_heap_op(op));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, op.key, op.node, op.mode};
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
          all_sent = 1'b1;
        end
      end
    end
  end

  // Receiver and checker: stalls follow a rotating pattern with random spells.
  always @(posedge clk_i) begin
    heap_res_t got;
    heap_res_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.node = m_axis_tdata[15:0];
        got.key = m_axis_tdata[47:16];
        got.status = m_axis_tdata[50:48];
        got.occ = m_axis_tdata[67:51];
        checked++;
        if (got.status == ihd_pkg::ST_POPPED) pops_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: node %h/%h key %h/%h status %0d/%0d occupancy %0d/%0d",
                       exp_r.node, got.node, exp_r.key, got.key, exp_r.status,
                       got.status, exp_r.occ, got.occ);
          end
        end
      end
      stall_phase++;
      if (stall_phase % 500 < 150) m_axis_tready <= 1'b1;
      else if (stall_phase % 7 == 3) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: the position sweep after reset is covered by waiting for ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tready) ready_seen = 1'b1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (ready_seen || idle_cycles < 70000 + WATCHDOG_LIMIT)
        idle_cycles++;
      if (idle_cycles >= (ready_seen ? WATCHDOG_LIMIT : 70000 + WATCHDOG_LIMIT)) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (all_sent && !s_axis_tvalid && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d results, %0d of them pops, against the predicted heap.", checked,
             pops_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches,
               expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ihd_pkg.sv
rtl/ihd_ram.sv
rtl/indexed_min_heap_decrease_key.sv
test/tb.sv
